FILE: rtl/core/s3x_pkg.sv
// shared types, constants and the scale3x block rule for the upscaler core
package s3x_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int PIX_W         = 8;
   localparam int COL_OUT_W     = 10;
   localparam int ROW_W         = 12;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int DIM_W         = 14;
   localparam int PEND_W        = 4;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [8:0] blk_type;

   typedef struct packed {
      pix_type                pix;
      pix_type                up;
      pix_type                mid;
      logic [COL_OUT_W-1:0]   x_lo;
      logic [ROW_W-1:0]       y;
      logic [PEND_W-1:0]      pend;
      logic                   x_ge1;
      logic                   x_ge2;
      logic                   y_ge1;
      logic                   y_ge2;
      logic                   x_in;
      logic                   x_in1;
      logic                   x_in2;
      logic                   y_in;
      logic                   y_in1;
      logic                   y_in2;
   } load_type;

   // neighbourhood a..i in slots 0..8, result block row major
   function automatic blk_type scale3x(input blk_type nb);
      pix_type a, b, c, d, e, f, g, h, i;
      logic    k1, k3, k7, k9;
      blk_type o;
      a  = nb[0];
      b  = nb[1];
      c  = nb[2];
      d  = nb[3];
      e  = nb[4];
      f  = nb[5];
      g  = nb[6];
      h  = nb[7];
      i  = nb[8];
      k1 = (d == b) && (d != h) && (b != f);
      k3 = (b == f) && (b != d) && (f != h);
      k7 = (h == d) && (h != f) && (d != b);
      k9 = (f == h) && (f != b) && (h != d);
      o[0] = k1 ? d : e;
      o[1] = ((k1 && e != c) || (k3 && e != a)) ? b : e;
      o[2] = k3 ? f : e;
      o[3] = ((k7 && e != a) || (k1 && e != g)) ? d : e;
      o[4] = e;
      o[5] = ((k3 && e != i) || (k9 && e != c)) ? f : e;
      o[6] = k7 ? d : e;
      o[7] = ((k9 && e != g) || (k7 && e != i)) ? h : e;
      o[8] = k9 ? f : e;
      return o;
   endfunction

endpackage

FILE: rtl/core/scale3x_pixel_upscaler_core.sv
// top level of the scale3x upscaler: position counters, input stage, line stores, emitter
//
//   channel   dir   handshake             payload
//   req_      in    req_valid/req_ready   req_pixel_in
//   rsp_      out   rsp_valid/rsp_ready   rsp_out_* (9 px), rsp_src_col, rsp_src_row,
//                                         rsp_run_last
//   csr_      in    csr_we                csr_index, csr_wdata
//
// one pixel beat per cycle unless rsp_ready stalls; row-end and frame-end pixels hold the input
// for each extra block (up to four result beats per pixel), set by the single result register
// accepted pixel: input stage register, then window, then result register
// line store read data is registered, a pixel at the same column as the one
// before it (width one) takes the forwarded value
// reset is synchronous; line stores are not cleared, pending blocks are dropped
// a stalled rsp_ready holds the result register and, once the input stage is full, req_ready
module scale3x_pixel_upscaler_core #(
   parameter int MAX_WIDTH = s3x_pkg::MAX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  s3x_pkg::pix_type                     req_pixel_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output s3x_pkg::pix_type                     rsp_out_top_left,
   output s3x_pkg::pix_type                     rsp_out_top_mid,
   output s3x_pkg::pix_type                     rsp_out_top_right,
   output s3x_pkg::pix_type                     rsp_out_mid_left,
   output s3x_pkg::pix_type                     rsp_out_centre,
   output s3x_pkg::pix_type                     rsp_out_mid_right,
   output s3x_pkg::pix_type                     rsp_out_bot_left,
   output s3x_pkg::pix_type                     rsp_out_bot_mid,
   output s3x_pkg::pix_type                     rsp_out_bot_right,
   output logic [s3x_pkg::COL_OUT_W-1:0]        rsp_src_col,
   output logic [s3x_pkg::ROW_W-1:0]            rsp_src_row,
   output logic                                 rsp_run_last,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [s3x_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [s3x_pkg::WIDTH_REG_W-1:0]   width_ff;
   logic [s3x_pkg::HEIGHT_REG_W-1:0]  height_ff;
   logic [s3x_pkg::DIM_W-1:0]         eff_w;
   logic [s3x_pkg::HEIGHT_REG_W-1:0]  eff_h;

   logic [COL_W-1:0]                  col_ff;
   logic [COL_W-1:0]                  col_in;
   logic [s3x_pkg::ROW_W-1:0]         row_ff;
   logic [s3x_pkg::ROW_W-1:0]         row_in;
   logic [COL_W-1:0]                  x;
   logic [COL_W+s3x_pkg::COL_OUT_W-1:0] x_wide;
   logic                              last_col;
   logic                              last_row;
   logic                              accept;

   logic                              s1_valid_ff;
   logic [COL_W-1:0]                  s1_addr_ff;
   s3x_pkg::load_type                 s1_ff;
   s3x_pkg::load_type                 s1_in;
   s3x_pkg::load_type                 load_data;
   logic                              advance;
   logic                              emit_free;
   s3x_pkg::pix_type                  rd_up;
   s3x_pkg::pix_type                  rd_mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= s3x_pkg::WIDTH_REG_W'(1024);
         height_ff <= s3x_pkg::HEIGHT_REG_W'(1024);
      end else if (csr_we) begin
         case (csr_index)
            s3x_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[s3x_pkg::WIDTH_REG_W-1:0];
            end
            s3x_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[s3x_pkg::HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = s3x_pkg::DIM_W'(1);
      end else if (s3x_pkg::DIM_W'(width_ff) > s3x_pkg::DIM_W'(MAX_WIDTH)) begin
         eff_w = s3x_pkg::DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = s3x_pkg::DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = s3x_pkg::HEIGHT_REG_W'(1);
      end else if (height_ff > s3x_pkg::HEIGHT_REG_W'(s3x_pkg::MAX_HEIGHT)) begin
         eff_h = s3x_pkg::HEIGHT_REG_W'(s3x_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign x = ({1'b0, col_ff} >= (COL_W+1)'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1) : col_ff;
   assign x_wide   = {{s3x_pkg::COL_OUT_W{1'b0}}, x};
   assign last_col = (s3x_pkg::DIM_W'(x) + s3x_pkg::DIM_W'(1)) >= eff_w;
   assign last_row = ({1'b0, row_ff} + s3x_pkg::HEIGHT_REG_W'(1)) >= eff_h;
   assign col_in   = last_col ? '0 : x + COL_W'(1);
   assign row_in   = last_col ? (last_row ? '0 : row_ff + s3x_pkg::ROW_W'(1)) : row_ff;

   assign advance   = s1_valid_ff && emit_free;
   assign req_ready = !s1_valid_ff || emit_free;
   assign accept    = req_valid && req_ready;

   // column and row x-k, y-k still inside the current geometry
   always_comb begin
      s1_in       = '0;
      s1_in.pix   = req_pixel_in;
      s1_in.x_lo  = x_wide[s3x_pkg::COL_OUT_W-1:0];
      s1_in.y     = row_ff;
      s1_in.x_ge1 = (x >= COL_W'(1));
      s1_in.x_ge2 = (COL_W'(x >> 1) != '0);
      s1_in.y_ge1 = (row_ff >= s3x_pkg::ROW_W'(1));
      s1_in.y_ge2 = (row_ff >= s3x_pkg::ROW_W'(2));
      s1_in.x_in  = s3x_pkg::DIM_W'(x) < eff_w;
      s1_in.x_in1 = s3x_pkg::DIM_W'(x) <= eff_w;
      s1_in.x_in2 = s3x_pkg::DIM_W'(x) <= eff_w + s3x_pkg::DIM_W'(1);
      s1_in.y_in  = {1'b0, row_ff} < eff_h;
      s1_in.y_in1 = {1'b0, row_ff} <= eff_h;
      s1_in.y_in2 = {1'b0, row_ff} <= eff_h + s3x_pkg::HEIGHT_REG_W'(1);
      s1_in.pend  = {last_row && last_col,
                     last_row && s1_in.x_ge1,
                     s1_in.y_ge1 && last_col,
                     s1_in.y_ge1 && s1_in.x_ge1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= s1_in;
         s1_addr_ff <= x;
      end
   end

   s3x_line_buf #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (COL_W)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (x),
      .wr_en   (advance),
      .wr_addr (s1_addr_ff),
      .wr_up   (rd_mid),
      .wr_mid  (s1_ff.pix),
      .rd_up   (rd_up),
      .rd_mid  (rd_mid)
   );

   always_comb begin
      load_data     = s1_ff;
      load_data.up  = rd_up;
      load_data.mid = rd_mid;
   end

   s3x_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .load              (advance),
      .load_data         (load_data),
      .free              (emit_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_top_left  (rsp_out_top_left),
      .rsp_out_top_mid   (rsp_out_top_mid),
      .rsp_out_top_right (rsp_out_top_right),
      .rsp_out_mid_left  (rsp_out_mid_left),
      .rsp_out_centre    (rsp_out_centre),
      .rsp_out_mid_right (rsp_out_mid_right),
      .rsp_out_bot_left  (rsp_out_bot_left),
      .rsp_out_bot_mid   (rsp_out_bot_mid),
      .rsp_out_bot_right (rsp_out_bot_right),
      .rsp_src_col       (rsp_src_col),
      .rsp_src_row       (rsp_src_row),
      .rsp_run_last      (rsp_run_last)
   );

endmodule

FILE: rtl/core/s3x_line_buf.sv
// two line stores packed in one memory, registered read with write forwarding
module s3x_line_buf #(
   parameter int MAX_WIDTH = s3x_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  s3x_pkg::pix_type    wr_up,
   input  s3x_pkg::pix_type    wr_mid,
   output s3x_pkg::pix_type    rd_up,
   output s3x_pkg::pix_type    rd_mid
);

   logic [2*s3x_pkg::PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*s3x_pkg::PIX_W-1:0] rd_data_ff;
   logic [2*s3x_pkg::PIX_W-1:0] fwd_data_ff;
   logic                        fwd_ff;
   logic                        fwd_in;

   assign fwd_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_up, wr_mid};
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= {wr_up, wr_mid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_up  = fwd_ff ? fwd_data_ff[2*s3x_pkg::PIX_W-1:s3x_pkg::PIX_W]
                          : rd_data_ff[2*s3x_pkg::PIX_W-1:s3x_pkg::PIX_W];
   assign rd_mid = fwd_ff ? fwd_data_ff[s3x_pkg::PIX_W-1:0]
                          : rd_data_ff[s3x_pkg::PIX_W-1:0];

endmodule

FILE: rtl/core/s3x_emit.sv
// 3x3 window, pending block list, scale3x rule and result register
module s3x_emit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  s3x_pkg::load_type                    load_data,
   output logic                                 free,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output s3x_pkg::pix_type                     rsp_out_top_left,
   output s3x_pkg::pix_type                     rsp_out_top_mid,
   output s3x_pkg::pix_type                     rsp_out_top_right,
   output s3x_pkg::pix_type                     rsp_out_mid_left,
   output s3x_pkg::pix_type                     rsp_out_centre,
   output s3x_pkg::pix_type                     rsp_out_mid_right,
   output s3x_pkg::pix_type                     rsp_out_bot_left,
   output s3x_pkg::pix_type                     rsp_out_bot_mid,
   output s3x_pkg::pix_type                     rsp_out_bot_right,
   output logic [s3x_pkg::COL_OUT_W-1:0]        rsp_src_col,
   output logic [s3x_pkg::ROW_W-1:0]            rsp_src_row,
   output logic                                 rsp_run_last
);

   s3x_pkg::pix_type                  win_ff [3][3];
   s3x_pkg::load_type                 cur_ff;
   logic [s3x_pkg::PEND_W-1:0]        pend_ff;
   logic [s3x_pkg::PEND_W-1:0]        pend_in;
   logic [s3x_pkg::PEND_W-1:0]        low;
   logic [s3x_pkg::PEND_W-1:0]        pend_rest;
   logic                              issue;
   logic                              cc2;
   logic                              rr2;
   logic [3:0]                        row_ok;
   logic [3:0]                        col_ok;
   s3x_pkg::pix_type                  ctr;
   s3x_pkg::blk_type                  nb;
   s3x_pkg::blk_type                  blk;
   logic                              rsp_valid_ff;
   s3x_pkg::blk_type                  blk_ff;
   logic [s3x_pkg::COL_OUT_W-1:0]     col_ff;
   logic [s3x_pkg::ROW_W-1:0]         row_ff;
   logic                              last_ff;

   assign low       = pend_ff & (~pend_ff + s3x_pkg::PEND_W'(1));
   assign pend_rest = pend_ff & ~low;
   assign issue     = (pend_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign pend_in   = issue ? pend_rest : pend_ff;
   assign free      = (pend_in == '0);

   assign cc2 = low[1] | low[3];
   assign rr2 = low[2] | low[3];

   // window rows y-2..y and columns x-2..x inside the image, slot 3 lies past the window
   always_comb begin
      logic [1:0] wr;
      logic [1:0] wc;
      row_ok[0] = cur_ff.y_ge2 && cur_ff.y_in2;
      row_ok[1] = cur_ff.y_ge1 && cur_ff.y_in1;
      row_ok[2] = cur_ff.y_in;
      row_ok[3] = 1'b0;
      col_ok[0] = cur_ff.x_ge2 && cur_ff.x_in2;
      col_ok[1] = cur_ff.x_ge1 && cur_ff.x_in1;
      col_ok[2] = cur_ff.x_in;
      col_ok[3] = 1'b0;
      ctr = win_ff[rr2 ? 2 : 1][cc2 ? 2 : 1];
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            wr = 2'(r) + {1'b0, rr2};
            wc = 2'(c) + {1'b0, cc2};
            if (row_ok[wr] && col_ok[wc]) begin
               nb[r*3+c] = win_ff[wr][wc];
            end else begin
               nb[r*3+c] = ctr;
            end
         end
      end
      blk = s3x_pkg::scale3x(nb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (load) begin
         pend_ff <= load_data.pend;
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= load_data.up;
         win_ff[1][2] <= load_data.mid;
         win_ff[2][2] <= load_data.pix;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (issue) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         blk_ff  <= blk;
         col_ff  <= cc2 ? cur_ff.x_lo : cur_ff.x_lo - s3x_pkg::COL_OUT_W'(1);
         row_ff  <= rr2 ? cur_ff.y : cur_ff.y - s3x_pkg::ROW_W'(1);
         last_ff <= (pend_rest == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_top_left  = blk_ff[0];
   assign rsp_out_top_mid   = blk_ff[1];
   assign rsp_out_top_right = blk_ff[2];
   assign rsp_out_mid_left  = blk_ff[3];
   assign rsp_out_centre    = blk_ff[4];
   assign rsp_out_mid_right = blk_ff[5];
   assign rsp_out_bot_left  = blk_ff[6];
   assign rsp_out_bot_mid   = blk_ff[7];
   assign rsp_out_bot_right = blk_ff[8];
   assign rsp_src_col       = col_ff;
   assign rsp_src_row       = row_ff;
   assign rsp_run_last      = last_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("window loaded while blocks still pending");

   a_pend_after_load: assert property (@(posedge clock) disable iff (reset)
      load && (load_data.pend != '0) |=> pend_ff != '0)
      else $error("pending blocks lost on load");

   a_run_last_on_final: assert property (@(posedge clock) disable iff (reset)
      issue && (pend_rest == '0) |=> rsp_valid && rsp_run_last)
      else $error("final block of a pixel without run_last");

   a_one_pending_issue: assert property (@(posedge clock) disable iff (reset)
      issue |-> $onehot(low))
      else $error("block select not one-hot");
`endif

endmodule

FILE: verif/s3x_block_scoreboard_pkg.sv
// scoreboard class for the scale3x upscaler: block predictor and expected beat store
package s3x_block_scoreboard_pkg;
   import s3x_pkg::*;

   typedef struct packed {
      blk_type                px;
      logic [COL_OUT_W-1:0]   col;
      logic [ROW_W-1:0]       row;
      logic                   last;
   } block_beat_t;

   class s3x_block_scoreboard;
      pix_type                 upper_store [MAX_WIDTH_DEF];
      pix_type                 middle_store [MAX_WIDTH_DEF];
      pix_type                 win_px [9];
      int unsigned             col_pos;
      int unsigned             row_pos;
      logic [WIDTH_REG_W-1:0]  width_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      int                      eff_w;
      int                      eff_h;
      block_beat_t             expected_q [$];
      int                      mismatches;
      int                      blocks_checked;
      int                      pixels_noted;

      function new();
         foreach (upper_store[k]) begin
            upper_store[k] = '0;
            middle_store[k] = '0;
         end
         foreach (win_px[k]) win_px[k] = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = WIDTH_REG_W'(1024);
         height_reg = HEIGHT_REG_W'(1024);
         mismatches = 0;
         blocks_checked = 0;
         pixels_noted = 0;
      endfunction

      function void write_reg(logic idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
         end else begin
            height_reg = data[HEIGHT_REG_W-1:0];
         end
      endfunction

      function int active_width();
         int w;
         w = (width_reg == 0) ? 1 : int'(width_reg);
         return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
      endfunction

      function int active_height();
         int h;
         h = (height_reg == 0) ? 1 : int'(height_reg);
         return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      endfunction

      // neighbour outside the image or the window falls back to the centre
      function pix_type pick(int bx, int by, int cc, int rr, int dx, int dy, pix_type e);
         if (bx + dx < 0 || bx + dx >= eff_w || by + dy < 0 || by + dy >= eff_h)
            return e;
         if (cc + dx < 0 || cc + dx > 2 || rr + dy < 0 || rr + dy > 2)
            return e;
         return win_px[(rr + dy) * 3 + cc + dx];
      endfunction

      function block_beat_t expand(int bx, int by, int cc, int rr);
         pix_type     a, b, c, d, e, f, g, h, i;
         logic        k1, k3, k7, k9;
         block_beat_t blk;
         e = win_px[rr * 3 + cc];
         a = pick(bx, by, cc, rr, -1, -1, e);
         b = pick(bx, by, cc, rr, 0, -1, e);
         c = pick(bx, by, cc, rr, 1, -1, e);
         d = pick(bx, by, cc, rr, -1, 0, e);
         f = pick(bx, by, cc, rr, 1, 0, e);
         g = pick(bx, by, cc, rr, -1, 1, e);
         h = pick(bx, by, cc, rr, 0, 1, e);
         i = pick(bx, by, cc, rr, 1, 1, e);
         k1 = (d == b) && (d != h) && (b != f);
         k3 = (b == f) && (b != d) && (f != h);
         k7 = (h == d) && (h != f) && (d != b);
         k9 = (f == h) && (f != b) && (h != d);
         blk.px[0] = k1 ? d : e;
         blk.px[1] = ((k1 && e != c) || (k3 && e != a)) ? b : e;
         blk.px[2] = k3 ? f : e;
         blk.px[3] = ((k7 && e != a) || (k1 && e != g)) ? d : e;
         blk.px[4] = e;
         blk.px[5] = ((k3 && e != i) || (k9 && e != c)) ? f : e;
         blk.px[6] = k7 ? d : e;
         blk.px[7] = ((k9 && e != g) || (k7 && e != i)) ? h : e;
         blk.px[8] = k9 ? f : e;
         blk.col = COL_OUT_W'(bx);
         blk.row = ROW_W'(by);
         blk.last = 1'b0;
         return blk;
      endfunction

      function void note_pixel(pix_type p);
         int          x, y, n;
         pix_type     up, mid;
         logic        last_col, last_row;
         block_beat_t blk [4];
         n = 0;
         eff_w = active_width();
         eff_h = active_height();
         if (col_pos >= MAX_WIDTH_DEF) col_pos = MAX_WIDTH_DEF - 1;
         x = col_pos;
         y = row_pos;
         up = upper_store[x];
         mid = middle_store[x];
         upper_store[x] = mid;
         middle_store[x] = p;
         for (int r = 0; r < 3; r++) begin
            win_px[r * 3] = win_px[r * 3 + 1];
            win_px[r * 3 + 1] = win_px[r * 3 + 2];
         end
         win_px[2] = up;
         win_px[5] = mid;
         win_px[8] = p;
         last_col = (x + 1 >= eff_w);
         last_row = (y + 1 >= eff_h);
         if (y >= 1 && x >= 1) begin
            blk[n] = expand(x - 1, y - 1, 1, 1);
            n++;
         end
         if (y >= 1 && last_col) begin
            blk[n] = expand(x, y - 1, 2, 1);
            n++;
         end
         if (last_row && x >= 1) begin
            blk[n] = expand(x - 1, y, 1, 2);
            n++;
         end
         if (last_row && last_col) begin
            blk[n] = expand(x, y, 2, 2);
            n++;
         end
         for (int k = 0; k < n; k++) begin
            blk[k].last = (k == n - 1);
            expected_q.push_back(blk[k]);
         end
         if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row_pos + 1) & 12'hFFF);
         end else begin
            col_pos++;
         end
         pixels_noted++;
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("mismatch at block beat %0d: %s", blocks_checked, what);
      endtask

      task check_block(block_beat_t got);
         block_beat_t want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected block col %0d row %0d", got.col, got.row));
            return;
         end
         want = expected_q.pop_front();
         for (int k = 0; k < 9; k++) begin
            if (got.px[k] !== want.px[k])
               report($sformatf("block (%0d,%0d) pixel %0d: got %0d want %0d",
                                want.col, want.row, k, got.px[k], want.px[k]));
         end
         if (got.col !== want.col)
            report($sformatf("src_col got %0d want %0d", got.col, want.col));
         if (got.row !== want.row)
            report($sformatf("src_row got %0d want %0d", got.row, want.row));
         if (got.last !== want.last)
            report($sformatf("block (%0d,%0d) run_last got %0b want %0b",
                             want.col, want.row, got.last, want.last));
         blocks_checked++;
      endtask
   endclass

endpackage

FILE: verif/scale3x_pixel_upscaler_core_tb.sv
// testbench for the scale3x upscaler core: directed images, random frames, stall mixes
module scale3x_pixel_upscaler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import s3x_pkg::*;
   import s3x_block_scoreboard_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PIXELS = 144;

   localparam pix_type EDGE_A [9] = '{8'h00, 8'h00, 8'hFF,
                                      8'h00, 8'hFF, 8'hFF,
                                      8'hFF, 8'hFF, 8'h00};
   localparam pix_type EDGE_B [9] = '{8'hFF, 8'h00, 8'h00,
                                      8'hFF, 8'hFF, 8'h00,
                                      8'h00, 8'hFF, 8'hFF};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   pix_type                req_pixel_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   pix_type                rsp_out_top_left, rsp_out_top_mid, rsp_out_top_right;
   pix_type                rsp_out_mid_left, rsp_out_centre, rsp_out_mid_right;
   pix_type                rsp_out_bot_left, rsp_out_bot_mid, rsp_out_bot_right;
   logic [COL_OUT_W-1:0]   rsp_src_col;
   logic [ROW_W-1:0]       rsp_src_row;
   logic                   rsp_run_last;
   logic                   csr_we = 1'b0;
   logic                   csr_index = 1'b0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   s3x_block_scoreboard    sb = new();
   int                     send_idle_pct = 13;
   int                     recv_idle_pct = 75;
   int                     cycle_count = 0;
   int                     csr_writes = 0;
   pix_type                palette [4];
   bit                     full_range;

   scale3x_pixel_upscaler_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_top_left  (rsp_out_top_left),
      .rsp_out_top_mid   (rsp_out_top_mid),
      .rsp_out_top_right (rsp_out_top_right),
      .rsp_out_mid_left  (rsp_out_mid_left),
      .rsp_out_centre    (rsp_out_centre),
      .rsp_out_mid_right (rsp_out_mid_right),
      .rsp_out_bot_left  (rsp_out_bot_left),
      .rsp_out_bot_mid   (rsp_out_bot_mid),
      .rsp_out_bot_right (rsp_out_bot_right),
      .rsp_src_col       (rsp_src_col),
      .rsp_src_row       (rsp_src_row),
      .rsp_run_last      (rsp_run_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d blocks still owed",
                  cycle_count, sb.expected_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin : rsp_monitor
      block_beat_t seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.px[0] = rsp_out_top_left;
         seen.px[1] = rsp_out_top_mid;
         seen.px[2] = rsp_out_top_right;
         seen.px[3] = rsp_out_mid_left;
         seen.px[4] = rsp_out_centre;
         seen.px[5] = rsp_out_mid_right;
         seen.px[6] = rsp_out_bot_left;
         seen.px[7] = rsp_out_bot_mid;
         seen.px[8] = rsp_out_bot_right;
         seen.col = rsp_src_col;
         seen.row = rsp_src_row;
         seen.last = rsp_run_last;
         sb.check_block(seen);
      end
   end

   task automatic send_pixel(input pix_type p);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(p);
   endtask

   // drop valid, let every owed block out, then give the pipe time to empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] data);
      settle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, data);
      csr_writes++;
   endtask

   function automatic pix_type pick_pixel();
      return full_range ? pix_type'($urandom) : palette[$urandom_range(3)];
   endfunction

   task automatic random_segment(input int budget, output int used);
      logic [CSR_DATA_W-1:0] wval, hval;
      int                    w_eff, h_eff, row_left, col_left, remaining;
      if (sb.col_pos == 0 && sb.row_pos == 0) begin
         case ($urandom_range(11))
            0:       wval = '0;
            1:       wval = CSR_DATA_W'($urandom_range(1025, 8191));
            default: wval = CSR_DATA_W'($urandom_range(1, 8));
         endcase
         case ($urandom_range(11))
            0:       hval = '0;
            1:       hval = CSR_DATA_W'($urandom_range(4097, 8191));
            default: hval = CSR_DATA_W'($urandom_range(1, 6));
         endcase
         if ($urandom_range(4) != 0) write_csr(CSR_IMAGE_WIDTH, wval);
         if ($urandom_range(4) != 0) write_csr(CSR_IMAGE_HEIGHT, hval);
      end else if ($urandom_range(2) == 0) begin
         // mid-frame the width may only shrink, so no unwritten column is read
         if ($urandom_range(1))
            write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(0, sb.active_width())));
         else
            write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(0, 8)));
      end
      w_eff = sb.active_width();
      h_eff = sb.active_height();
      row_left = (sb.row_pos + 1 >= h_eff) ? 1 : h_eff - int'(sb.row_pos);
      col_left = (sb.col_pos + 1 >= w_eff) ? 1 : w_eff - int'(sb.col_pos);
      remaining = col_left + (row_left - 1) * w_eff;
      if ($urandom_range(3) != 0)
         used = (remaining > 40) ? 40 : remaining;
      else
         used = $urandom_range(1, 12);
      if (used > budget) used = budget;
      full_range = ($urandom_range(3) == 0);
      foreach (palette[k]) palette[k] = pix_type'($urandom);
      if ($urandom_range(1)) begin
         palette[0] = 8'h00;
         palette[1] = 8'hFF;
      end
      repeat (used) send_pixel(pick_pixel());
   endtask

   initial begin
      int random_sent;
      int used;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      write_csr(CSR_IMAGE_HEIGHT, 13'd3);
      foreach (EDGE_A[k]) send_pixel(EDGE_A[k]);
      foreach (EDGE_B[k]) send_pixel(EDGE_B[k]);
      // width zero acts as one
      write_csr(CSR_IMAGE_WIDTH, 13'h1800);
      write_csr(CSR_IMAGE_HEIGHT, 13'd2);
      send_pixel(8'h81);
      send_pixel(8'h7E);
      write_csr(CSR_IMAGE_HEIGHT, 13'd0);
      send_pixel(8'hFF);
      // oversize geometry, then shrink it under a frame in progress
      write_csr(CSR_IMAGE_WIDTH, 13'h1FFF);
      write_csr(CSR_IMAGE_HEIGHT, 13'h1FFF);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h5A);
      write_csr(CSR_IMAGE_HEIGHT, 13'd1);
      send_pixel(8'h5A);
      send_pixel(8'hA5);
      write_csr(CSR_IMAGE_WIDTH, 13'd2);
      send_pixel(8'h3C);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 13;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 13;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         random_sent = 0;
         while (random_sent < RANDOM_PIXELS / 3) begin
            random_segment(RANDOM_PIXELS / 3 - random_sent, used);
            random_sent += used;
         end
      end

      settle();
      $display("%0d pixel beats in, %0d block beats checked, %0d register writes, %0d cycles",
               sb.pixels_noted, sb.blocks_checked, csr_writes, cycle_count);
      $display("geometries from 1x1 to 1024x4096 incl. zero, oversize and mid-frame changes");
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/s3x_pkg.sv
rtl/core/s3x_line_buf.sv
rtl/core/s3x_emit.sv
rtl/core/scale3x_pixel_upscaler_core.sv
verif/s3x_block_scoreboard_pkg.sv
verif/scale3x_pixel_upscaler_core_tb.sv
